// ----- src/outlier_trimmed_moving_average_macros.svh -----
// Assertion helpers shared by the checkers of this block.
// Every check runs on the rising edge of aclk and is off while aresetn is low.
`ifndef OUTLIER_TRIMMED_MOVING_AVERAGE_MACROS_SVH
`define OUTLIER_TRIMMED_MOVING_AVERAGE_MACROS_SVH

// Same-cycle implication.
`define OTMA_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("otma check failed: same-cycle implication");

// Next-cycle implication.
`define OTMA_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("otma check failed: next-cycle implication");

// Condition that holds on every edge.
`define OTMA_ASSERT_ALW(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("otma check failed: invariant");

`endif

// ----- src/otma_pkg.sv -----
`timescale 1ns / 1ps

package otma_pkg;

    // Window store depth
    localparam int MAX_WINDOW = 16;

    // Fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int WLEN_W   = 5;
    localparam int CFG_W    = 32;

    // Derived widths
    localparam int POS_W     = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int COUNT_W   = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W     = SAMPLE_W + POS_W;
    localparam int DIV_CNT_W = $clog2(SUM_W + 1);

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_DEV_LIMIT     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LENGTH = 1'b1;

    // Register reset values
    localparam logic [SAMPLE_W-1:0] DEV_LIMIT_RESET     = '1;
    localparam logic [WLEN_W-1:0]   WINDOW_LENGTH_RESET = 5'd16;

    // Controller states, one-hot
    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EVAL   = 5'b00010,
        ST_ADD    = 5'b00100,
        ST_DIVIDE = 5'b01000,
        ST_EMIT   = 5'b10000
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic load_sample;  // input transfer, capture sample and read old entry
        logic evaluate;     // outlier test, ring update, sum subtract
        logic add_sum;      // add new sample, start divider
        logic emit;         // load result into output register
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic reject;       // sample is an outlier (valid with evaluate)
        logic div_done;     // quotient ready
        logic out_free;     // output register can take a result
    } status_t;

endpackage

// ----- src/otma_ram.sv -----
`timescale 1ns / 1ps

// Simple dual-port RAM, registered read.
module otma_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/otma_div.sv -----
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle.
module otma_div (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic [otma_pkg::SUM_W-1:0]   dividend,
    input  logic [otma_pkg::COUNT_W-1:0] divisor,
    output logic [otma_pkg::SUM_W-1:0]   quotient,
    output logic                         done
);

    logic [otma_pkg::SUM_W-1:0]     quo_reg;
    logic [otma_pkg::COUNT_W-1:0]   rem_reg;
    logic [otma_pkg::COUNT_W-1:0]   dvs_reg;
    logic [otma_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;

    logic [otma_pkg::COUNT_W:0]   trial;
    logic                         fits;
    logic [otma_pkg::COUNT_W:0]   trial_sub;

    // Shift in next dividend bit and try a subtract
    always_comb begin
        trial     = {rem_reg, quo_reg[otma_pkg::SUM_W-1]};
        fits      = (trial >= {1'b0, dvs_reg});
        trial_sub = trial - {1'b0, dvs_reg};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= otma_pkg::DIV_CNT_W'(otma_pkg::SUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - otma_pkg::DIV_CNT_W'(1);
                if (cnt_reg == otma_pkg::DIV_CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[otma_pkg::SUM_W-2:0], fits};
            rem_reg <= fits ? trial_sub[otma_pkg::COUNT_W-1:0]
                            : trial[otma_pkg::COUNT_W-1:0];
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ----- src/otma_ctrl.sv -----
`timescale 1ns / 1ps

// Sequencer for one sample at a time.
module otma_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  otma_pkg::status_t status,
    output otma_pkg::cmd_t    cmd
);

    otma_pkg::state_t state_reg;
    otma_pkg::state_t state_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            otma_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = otma_pkg::ST_EVAL;
                end
            end
            otma_pkg::ST_EVAL: begin
                state_next = status.reject ? otma_pkg::ST_EMIT : otma_pkg::ST_ADD;
            end
            otma_pkg::ST_ADD: begin
                state_next = otma_pkg::ST_DIVIDE;
            end
            otma_pkg::ST_DIVIDE: begin
                if (status.div_done) begin
                    state_next = otma_pkg::ST_EMIT;
                end
            end
            otma_pkg::ST_EMIT: begin
                if (status.out_free) begin
                    state_next = otma_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = otma_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= otma_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign s_tready        = (state_reg == otma_pkg::ST_IDLE);
    assign cmd.load_sample = (state_reg == otma_pkg::ST_IDLE) && s_tvalid;
    assign cmd.evaluate    = (state_reg == otma_pkg::ST_EVAL);
    assign cmd.add_sum     = (state_reg == otma_pkg::ST_ADD);
    assign cmd.emit        = (state_reg == otma_pkg::ST_EMIT) && status.out_free;

endmodule

// ----- src/otma_dp.sv -----
`timescale 1ns / 1ps

// Registers, window store, sum, divider and output register.
module otma_dp (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [otma_pkg::CFG_IDX_W-1:0]       cfg_wr_index,
    input  logic [otma_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic [otma_pkg::SAMPLE_W-1:0]        s_tdata,
    input  otma_pkg::cmd_t                       cmd,
    output otma_pkg::status_t                    status,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [otma_pkg::SAMPLE_W-1:0]        m_tdata,
    output logic [0:0]                           m_tuser
);

    // Configuration
    logic [otma_pkg::SAMPLE_W-1:0] thr_reg;
    logic [otma_pkg::WLEN_W-1:0]   wlen_reg;

    // Filter state
    logic [otma_pkg::SAMPLE_W-1:0] sample_reg;
    logic [otma_pkg::COUNT_W-1:0]  count_reg;
    logic [otma_pkg::POS_W-1:0]    pos_reg;
    logic [otma_pkg::SUM_W-1:0]    sum_reg;
    logic [otma_pkg::SAMPLE_W-1:0] avg_reg;
    logic                          rejected_reg;

    // Output register
    logic                          m_valid_reg;
    logic [otma_pkg::SAMPLE_W-1:0] m_data_reg;
    logic                          m_changed_reg;

    logic [otma_pkg::COUNT_W-1:0]  eff_len;
    logic [otma_pkg::SAMPLE_W-1:0] diff;
    logic                          reject_now;
    logic                          window_full;
    logic [otma_pkg::COUNT_W-1:0]  pos_inc;
    logic [otma_pkg::SAMPLE_W-1:0] old_sample;
    logic [otma_pkg::SUM_W-1:0]    sum_sub;
    logic [otma_pkg::SUM_W-1:0]    sum_add;
    logic [otma_pkg::SUM_W-1:0]    quotient;
    logic [otma_pkg::SAMPLE_W-1:0] new_avg;
    logic                          div_done;
    logic                          ram_we;

    // Window length saturated to 1..MAX_WINDOW
    always_comb begin
        if (wlen_reg == '0) begin
            eff_len = otma_pkg::COUNT_W'(1);
        end else if (32'(wlen_reg) > 32'(otma_pkg::MAX_WINDOW)) begin
            eff_len = otma_pkg::COUNT_W'(otma_pkg::MAX_WINDOW);
        end else begin
            eff_len = otma_pkg::COUNT_W'(wlen_reg);
        end
    end

    // Outlier test against current average
    always_comb begin
        diff       = (sample_reg >= avg_reg) ? (sample_reg - avg_reg)
                                             : (avg_reg - sample_reg);
        reject_now = (count_reg != '0) && (diff > thr_reg);
    end

    // Ring bookkeeping and sum update
    always_comb begin
        window_full = (count_reg >= eff_len);
        pos_inc     = otma_pkg::COUNT_W'(pos_reg) + otma_pkg::COUNT_W'(1);
        sum_sub     = sum_reg - (window_full ? otma_pkg::SUM_W'(old_sample)
                                             : otma_pkg::SUM_W'(0));
        sum_add     = sum_reg + otma_pkg::SUM_W'(sample_reg);
        new_avg     = quotient[otma_pkg::SAMPLE_W-1:0];
        ram_we      = cmd.evaluate && !reject_now;
    end

    otma_ram #(
        .WIDTH (otma_pkg::SAMPLE_W),
        .DEPTH (otma_pkg::MAX_WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (pos_reg),
        .wdata (sample_reg),
        .raddr (pos_reg),
        .rdata (old_sample)
    );

    otma_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.add_sum),
        .dividend (sum_add),
        .divisor  (count_reg),
        .quotient (quotient),
        .done     (div_done)
    );

    // Sample capture
    always_ff @(posedge aclk) begin
        if (cmd.load_sample) begin
            sample_reg <= s_tdata;
        end
    end

    // Config and filter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg      <= otma_pkg::DEV_LIMIT_RESET;
            wlen_reg     <= otma_pkg::WINDOW_LENGTH_RESET;
            count_reg    <= '0;
            pos_reg      <= '0;
            sum_reg      <= '0;
            avg_reg      <= '0;
            rejected_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                otma_pkg::REG_DEV_LIMIT: begin
                    thr_reg <= cfg_wr_data[otma_pkg::SAMPLE_W-1:0];
                end
                otma_pkg::REG_WINDOW_LENGTH: begin
                    // restart the filter
                    wlen_reg  <= cfg_wr_data[otma_pkg::WLEN_W-1:0];
                    count_reg <= '0;
                    pos_reg   <= '0;
                    sum_reg   <= '0;
                    avg_reg   <= '0;
                end
                default: begin
                end
            endcase
        end else begin
            if (cmd.evaluate) begin
                rejected_reg <= reject_now;
                if (!reject_now) begin
                    if (!window_full) begin
                        count_reg <= count_reg + otma_pkg::COUNT_W'(1);
                    end
                    sum_reg <= sum_sub;
                    pos_reg <= (pos_inc >= eff_len) ? '0
                                                    : pos_inc[otma_pkg::POS_W-1:0];
                end
            end
            if (cmd.add_sum) begin
                sum_reg <= sum_add;
            end
            if (cmd.emit && !rejected_reg) begin
                avg_reg <= new_avg;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_data_reg    <= rejected_reg ? avg_reg : new_avg;
            m_changed_reg <= !rejected_reg && (new_avg != avg_reg);
        end
    end

    assign status.reject   = reject_now;
    assign status.div_done = div_done;
    assign status.out_free = !m_valid_reg || m_tready;

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tuser[0] = m_changed_reg;

endmodule

// ----- src/outlier_trimmed_moving_average.sv -----
`timescale 1ns / 1ps

// Moving average with outlier rejection over unsigned 32-bit samples. Each sample transfer on
// the s_ side yields exactly one result transfer on the m_ side: the floor average of the
// accepted samples in the window, plus a flag in m_tuser that is set when that average moved.
// The first sample after reset or after a window_length write is always taken; later samples
// further than the deviation limit (register 0) from the current average are dropped and
// return the old average with the flag clear. One sample is processed at a time. A dropped
// sample goes from the outlier test straight to the output register; an accepted sample
// first passes the sum update and then the restoring divider, which produces one quotient
// bit per cycle over the 36-bit running sum. A finished result waits in the output register
// while the next sample is processed; a result that cannot leave that register holds the
// block until it is taken.
// Writing window_length restarts the filter; the deviation limit applies from the next sample.
// Write configuration only while the block is idle.
module outlier_trimmed_moving_average (
    input  logic                           aclk,
    input  logic                           aresetn,
    // configuration write port
    input  logic                           cfg_wr_en,
    input  logic [otma_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [otma_pkg::CFG_W-1:0]     cfg_wr_data,
    // sample input
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [otma_pkg::SAMPLE_W-1:0]  s_tdata,   // [31:0] sample_value
    // result output
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [otma_pkg::SAMPLE_W-1:0]  m_tdata,   // [31:0] average_value
    output logic [0:0]                     m_tuser    // [0] average_changed
);

    otma_pkg::cmd_t    cmd;
    otma_pkg::status_t status;

    otma_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    otma_dp u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .s_tdata      (s_tdata),
        .cmd          (cmd),
        .status       (status),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser)
    );

endmodule

// ----- src/otma_checker.sv -----
`timescale 1ns / 1ps

`include "outlier_trimmed_moving_average_macros.svh"

// Port-level checks for the moving average block.
module otma_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [otma_pkg::SAMPLE_W-1:0] m_tdata,
    input logic [0:0]                    m_tuser
);

    logic       in_xfer;
    logic       out_xfer;
    logic [1:0] pending_reg;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Samples taken but results not yet delivered
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_reg + 2'(in_xfer) - 2'(out_xfer);
        end
    end

    // Stalled result holds
    `OTMA_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    // One sample in work at a time
    `OTMA_ASSERT_NXT(a_busy_after_in, in_xfer, !s_tready)
    // No result without a sample behind it
    `OTMA_ASSERT_IMP(a_no_invented, m_tvalid, pending_reg != 2'd0)
    // At most one in work and one waiting
    `OTMA_ASSERT_ALW(a_pending_bound, pending_reg != 2'd3)

endmodule

bind outlier_trimmed_moving_average otma_checker u_checker (.*);
